// ===== design/dted_pkg.sv =====
package dted_pkg;

	localparam int unsigned ENERGY_W = 24;
	localparam int unsigned ZCR_W = 16;
	localparam int unsigned COUNT_W = 24;
	localparam int unsigned QUIET_W = 8;
	localparam int unsigned SEGNUM_W = 16;
	localparam int unsigned MINLEN_W = 16;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned IN_TDATA_W = 40;
	localparam int unsigned OUT_TDATA_W = 88;

	localparam int unsigned MAX_SAMPLES_DEF = 16777216;

	// Register indexes on the write port.
	localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_HIGH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_LOW = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ZCR_LOW = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_FLOOR = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ZCR_FLOOR = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_SILENCE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_VOICE_LENGTH = 3'd6;

	localparam logic [ENERGY_W-1:0] ENERGY_HIGH_RST = 24'd655360;
	localparam logic [ENERGY_W-1:0] ENERGY_LOW_RST = 24'd131072;
	localparam logic [ZCR_W-1:0] ZCR_LOW_RST = 16'd1280;
	localparam logic [ENERGY_W-1:0] ENERGY_FLOOR_RST = 24'd0;
	localparam logic [ZCR_W-1:0] ZCR_FLOOR_RST = 16'd0;
	localparam logic [QUIET_W-1:0] MIN_SILENCE_RST = 8'd6;
	localparam logic [MINLEN_W-1:0] MIN_VOICE_LENGTH_RST = 16'd15;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy_high;
		logic [ENERGY_W-1:0] energy_low;
		logic [ZCR_W-1:0]    zcr_low;
		logic [ENERGY_W-1:0] energy_floor;
		logic [ZCR_W-1:0]    zcr_floor;
		logic [QUIET_W-1:0]  min_silence;
		logic [MINLEN_W-1:0] min_voice_length;
	} cfg_t;

	typedef struct packed {
		logic                last_sample;
		logic [ZCR_W-1:0]    sample_zcr;
		logic [ENERGY_W-1:0] sample_energy;
	} item_t;

	typedef struct packed {
		logic                last_result;
		logic [SEGNUM_W-1:0] seg_number;
		logic [COUNT_W-1:0]  seg_length;
		logic [COUNT_W-1:0]  seg_end;
		logic [COUNT_W-1:0]  seg_begin;
	} result_t;

	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
		return (a == {COUNT_W{1'b1}}) ? a : a + 1'b1;
	endfunction

endpackage

// ===== design/double_threshold_endpoint_detect.sv =====
// Voice endpoint detector with an energy / zero-crossing double threshold.
// The slave stream takes one transfer per audio sample: frame energy and
// frame zero-crossing rate in s_tdata, the final sample of a recording in
// s_tlast. The master stream gives one transfer per voice segment found:
// begin, end, length and ordinal in m_tdata, with m_tlast always set since a
// sample causes at most one segment. A segment is reported on the sample
// after it closes; on the last sample an open segment is flushed, and if the
// recording held none a segment starting at 0 is reported.
// One sample is taken every cycle while the output queue is not full. A sample
// is held in the input register, then the state update and any segment land
// in a two-entry output queue, and m_tvalid rises once a segment is queued.
// When the receiver stalls the queue fills, and s_tready drops once it is
// full with a sample waiting in the input register.
// Thresholds are written on the wr_* port while the block is idle; they take
// effect on the next sample. Reset loads the default thresholds, clears the
// detector state and empties the queue. After the last sample the detector
// state returns to its reset value and a new recording begins.
module double_threshold_endpoint_detect #(
	parameter int unsigned MAX_SAMPLES = dted_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [dted_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [dted_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sample_energy[23:0], sample_zcr[39:24]
	input  logic [dted_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// seg_begin[23:0], seg_end[47:24], seg_length[71:48], seg_number[87:72]
	output logic [dted_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast
);

	dted_pkg::cfg_t    cfg_q;
	dted_pkg::item_t   in_item;
	dted_pkg::result_t res;
	dted_pkg::result_t head;
	logic              res_push;
	logic              out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_high <= dted_pkg::ENERGY_HIGH_RST;
			cfg_q.energy_low <= dted_pkg::ENERGY_LOW_RST;
			cfg_q.zcr_low <= dted_pkg::ZCR_LOW_RST;
			cfg_q.energy_floor <= dted_pkg::ENERGY_FLOOR_RST;
			cfg_q.zcr_floor <= dted_pkg::ZCR_FLOOR_RST;
			cfg_q.min_silence <= dted_pkg::MIN_SILENCE_RST;
			cfg_q.min_voice_length <= dted_pkg::MIN_VOICE_LENGTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				dted_pkg::REG_ENERGY_HIGH: cfg_q.energy_high <= wr_data;
				dted_pkg::REG_ENERGY_LOW: cfg_q.energy_low <= wr_data;
				dted_pkg::REG_ZCR_LOW: cfg_q.zcr_low <= wr_data[dted_pkg::ZCR_W-1:0];
				dted_pkg::REG_ENERGY_FLOOR: cfg_q.energy_floor <= wr_data;
				dted_pkg::REG_ZCR_FLOOR: cfg_q.zcr_floor <= wr_data[dted_pkg::ZCR_W-1:0];
				dted_pkg::REG_MIN_SILENCE: begin
					cfg_q.min_silence <= wr_data[dted_pkg::QUIET_W-1:0];
				end
				dted_pkg::REG_MIN_VOICE_LENGTH: begin
					cfg_q.min_voice_length <= wr_data[dted_pkg::MINLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_item = {s_tlast, s_tdata};

	dted_step #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.out_full (out_full),
		.res_push (res_push),
		.res      (res)
	);

	dted_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.full      (out_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.head      (head)
	);

	assign m_tdata = {head.seg_number, head.seg_length, head.seg_end, head.seg_begin};
	assign m_tlast = head.last_result;

`ifndef ASSERT_OFF
	// A segment never enters a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !out_full)
		else $error("segment pushed into full output queue");

	// Input backpressure only comes from a full queue.
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> out_full)
		else $error("s_tready low while output queue has room");

	// Every reported segment closes the results of its sample.
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res.last_result)
		else $error("segment pushed without last marker");

	// A full queue holds its output until the receiver takes it.
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_full && !m_tready |=> out_full && m_tvalid)
		else $error("full output queue drained without a transfer");
`endif

endmodule

// ===== design/dted_out_fifo.sv =====
module dted_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dted_pkg::result_t   push_data,
	output logic                full,
	output logic                m_tvalid,
	input  logic                m_tready,
	output dted_pkg::result_t   head
);

	dted_pkg::result_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== design/dted_step.sv =====
module dted_step #(
	parameter int unsigned MAX_SAMPLES = dted_pkg::MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dted_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  dted_pkg::item_t    in_item,
	input  logic               out_full,
	output logic               res_push,
	output dted_pkg::result_t  res
);

	localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);
	localparam int unsigned CW = dted_pkg::COUNT_W;

	typedef enum logic [1:0] {
		MUTE,
		INTERIM,
		VOICE,
		OVER
	} mode_t;

	dted_pkg::item_t item_s1;
	logic            valid_s1;
	logic            advance;

	mode_t                        mode_q, mode_n;
	logic [IDX_W-1:0]             idx_q, idx_n;
	logic [CW-1:0]                vb_q, vb_n;
	logic [CW-1:0]                ve_q, ve_n;
	logic [CW-1:0]                vc_q, vc_n;
	logic [dted_pkg::QUIET_W-1:0] qc_q, qc_n;
	logic [dted_pkg::SEGNUM_W-1:0] sf_q, sf_n;

	logic [dted_pkg::QUIET_W-1:0] qc_sat;
	logic [CW:0]                  begin_sub;
	logic [CW:0]                  idx_ext;
	logic [CW-1:0]                begin_val;
	logic                         hit;
	dted_pkg::result_t            res_c;

	assign advance = valid_s1 && !out_full;
	assign in_ready = !valid_s1 || !out_full;

	// Segment start lies voice_count + 1 samples back, floored at zero.
	assign idx_ext = (CW + 1)'(idx_q);
	assign begin_sub = {1'b0, vc_q} + 1'b1;
	assign begin_val = (idx_ext >= begin_sub) ? CW'(idx_ext - begin_sub) : '0;
	assign qc_sat = (qc_q == '1) ? qc_q : qc_q + 1'b1;

	always_comb begin
		mode_n = mode_q;
		idx_n = idx_q;
		vb_n = vb_q;
		ve_n = ve_q;
		vc_n = vc_q;
		qc_n = qc_q;
		sf_n = sf_q;
		hit = 1'b0;
		res_c = '0;
		res_c.last_result = 1'b1;

		unique case (mode_q)
			MUTE, INTERIM: begin
				if (item_s1.sample_energy > cfg.energy_high) begin
					vb_n = begin_val;
					mode_n = VOICE;
					vc_n = dted_pkg::sat_inc(vc_q);
					qc_n = '0;
				end else if (item_s1.sample_energy > cfg.energy_low ||
						item_s1.sample_zcr > cfg.zcr_low) begin
					mode_n = INTERIM;
					vc_n = dted_pkg::sat_inc(vc_q);
				end else begin
					mode_n = MUTE;
					vc_n = '0;
				end
			end
			VOICE: begin
				if (item_s1.sample_energy > cfg.energy_floor ||
						item_s1.sample_zcr > cfg.zcr_floor) begin
					vc_n = dted_pkg::sat_inc(vc_q);
				end else begin
					qc_n = qc_sat;
					if (qc_sat < cfg.min_silence) begin
						vc_n = dted_pkg::sat_inc(vc_q);
					end else if (vc_q < CW'(cfg.min_voice_length)) begin
						mode_n = MUTE;
						qc_n = '0;
						vc_n = '0;
					end else begin
						mode_n = OVER;
						ve_n = dted_pkg::sat_add(vb_q, vc_q);
					end
				end
			end
			OVER: begin
				// The sample after a segment ends only reports it.
				hit = 1'b1;
				res_c.seg_begin = vb_q;
				res_c.seg_end = ve_q;
				res_c.seg_length = vc_q;
				res_c.seg_number = sf_q;
				vc_n = '0;
				sf_n = (sf_q == '1) ? sf_q : sf_q + 1'b1;
				mode_n = MUTE;
			end
			default: begin
				mode_n = MUTE;
			end
		endcase

		if (item_s1.last_sample) begin
			// A segment still open is flushed; a segment in the over state is still reported.
			if (mode_n == VOICE) begin
				hit = 1'b1;
				res_c.seg_begin = vb_n;
				res_c.seg_end = dted_pkg::sat_add(vb_n, vc_n);
				res_c.seg_length = vc_n;
				res_c.seg_number = sf_n;
				sf_n = (sf_n == '1) ? sf_n : sf_n + 1'b1;
			end
			if (sf_n == '0) begin
				hit = 1'b1;
				res_c.seg_begin = '0;
				res_c.seg_end = vc_n;
				res_c.seg_length = vc_n;
				res_c.seg_number = '0;
			end
			mode_n = MUTE;
			idx_n = '0;
			vb_n = '0;
			ve_n = '0;
			vc_n = '0;
			qc_n = '0;
			sf_n = '0;
		end else if (idx_q < IDX_MAX) begin
			idx_n = idx_q + 1'b1;
		end
	end

	assign res_push = advance && hit;
	assign res = res_c;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= MUTE;
			idx_q <= '0;
			vb_q <= '0;
			ve_q <= '0;
			vc_q <= '0;
			qc_q <= '0;
			sf_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q <= mode_n;
				idx_q <= idx_n;
				vb_q <= vb_n;
				ve_q <= ve_n;
				vc_q <= vc_n;
				qc_q <= qc_n;
				sf_q <= sf_n;
			end
		end
	end

endmodule
